@@ src/dcs_pkg.sv @@
// Shared types, constants and helper functions of the decayed cluster statistics block.
`timescale 1ns / 1ps
package dcs_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int DECAY_FRAC      = 16;
  localparam logic [16:0] DECAY_ONE = 17'd65536;

  typedef enum logic [2:0] {
    T_IDLE,
    T_WGT,
    T_START,
    T_LANE,
    T_SQRT,
    T_SQW,
    T_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    L_IDLE,
    L_DIV_STEP,
    L_CENTER,
    L_DIFF,
    L_TERM,
    L_TSAT,
    L_DECAY,
    L_SUM,
    L_RAD_GO,
    L_DIV_RAD,
    L_FINISH
  } lane_state_t;

  typedef struct packed {
    logic start;
    logic first;
  } lane_cmd_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

@@ src/dcs_div.sv @@
// Radix-4 restoring divider giving floor(num * 2^F / den) for den of at least 1.0.
`timescale 1ns / 1ps
module dcs_div #(
  parameter int FRAC_BITS = dcs_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [62:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [62:0] quo
);
  import dcs_pkg::*;

  localparam int DW = 63 + FRAC_BITS;

  logic [DW-1:0] dvd;
  logic [31:0]   rem_r, rem_nxt;
  logic [63:0]   sh_r, sh_nxt;
  logic [31:0]   den_r;
  logic [4:0]    cnt_r;
  logic          busy_r, done_r;

  assign dvd  = {num, {FRAC_BITS{1'b0}}};
  assign done = done_r;
  assign quo  = sh_r[62:0];

  // Two quotient bits a cycle; the remainder always stays below the divisor.
  always_comb begin
    logic [32:0] t;
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    for (int k = 0; k < 2; k++) begin
      t      = {rem_nxt, sh_nxt[63]};
      sh_nxt = {sh_nxt[62:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        rem_nxt   = 32'(t - {1'b0, den_r});
        sh_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= 32'(dvd >> 64);
        sh_r   <= dvd[63:0];
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        sh_r  <= sh_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/dcs_sqrt.sv @@
// Digit-by-digit integer square root of a 64-bit radicand, one result bit a cycle.
`timescale 1ns / 1ps
module dcs_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import dcs_pkg::*;

  logic [63:0] rad_r;
  logic [34:0] rem_r, r2, trial;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;

  assign done  = done_r;
  assign root  = root_r;
  assign r2    = {rem_r[32:0], rad_r[63:62]};
  assign trial = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r <= {rad_r[61:0], 2'b00};
        if (r2 >= trial) begin
          rem_r  <= r2 - trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= r2;
          root_r <= {root_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/dcs_lane.sv @@
// One coordinate lane: centre move, decayed spread update and spread over weight.
`timescale 1ns / 1ps
module dcs_lane #(
  parameter int SAMPLE_BITS = dcs_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = dcs_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dcs_pkg::lane_cmd_t      cmd,
  input  logic [SAMPLE_BITS-1:0]  sample,
  input  logic [31:0]             weight,
  input  logic [16:0]             decay,
  output logic                    done,
  output logic signed [31:0]      center,
  output logic [62:0]             spread,
  output logic [62:0]             rad_quo
);
  import dcs_pkg::*;

  lane_state_t state_r, state_nxt;

  logic signed [31:0] center_r;
  logic [62:0]        spread_r, term_r, rad_quo_r;
  logic signed [63:0] sf_r;
  logic [63:0]        mag_r;
  logic               neg_r;
  logic [63:0]        a_r, b_r;
  logic [127:0]       acc_r;
  logic [1:0]         cnt_r;

  logic signed [63:0] s64, sf, c64, delta, newc, d_new;
  logic [63:0]        mag, step, an;
  logic               div_start, div_done, same_sign;
  logic [62:0]        div_num, div_quo;
  logic [31:0]        ap, bp;
  logic [63:0]        prod;
  logic [127:0]       part;
  logic [63:0]        dv;

  assign s64   = {{(64-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
  assign sf    = s64 <<< FRAC_BITS;
  assign c64   = {{32{center_r[31]}}, center_r};
  assign delta = sf - c64;
  assign mag   = delta[63] ? 64'(-delta) : delta;
  assign step  = ({1'b0, div_quo} < mag_r) ? {1'b0, div_quo} : mag_r;
  assign newc  = neg_r ? c64 - $signed(step) : c64 + $signed(step);
  assign d_new = sf_r - c64;
  assign an    = d_new[63] ? 64'(-d_new) : d_new;
  // The old and new offsets from the sample share a sign, or one of them is zero.
  assign same_sign = (!neg_r && !d_new[63]) ||
                     ((neg_r || mag_r == 64'd0) && (d_new[63] || d_new == 64'sd0));

  assign ap   = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign bp   = cnt_r[0] ? b_r[63:32] : b_r[31:0];
  assign prod = ap * bp;
  always_comb begin
    case (cnt_r)
      2'd0:    part = {64'd0, prod};
      2'd3:    part = {prod, 64'd0};
      default: part = {32'd0, prod, 32'd0};
    endcase
  end

  assign dv      = {1'b0, acc_r[62+DECAY_FRAC:DECAY_FRAC]} + {1'b0, term_r};
  assign div_num = (state_r == L_RAD_GO) ? spread_r : mag[62:0];

  dcs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (weight),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    done      = 1'b0;
    case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          if (cmd.first) begin
            state_nxt = L_RAD_GO;
          end else begin
            div_start = 1'b1;
            state_nxt = L_DIV_STEP;
          end
        end
      end
      L_DIV_STEP: if (div_done) state_nxt = L_CENTER;
      L_CENTER:   state_nxt = L_DIFF;
      L_DIFF:     state_nxt = L_TERM;
      L_TERM:     if (cnt_r == 2'd3) state_nxt = L_TSAT;
      L_TSAT:     state_nxt = L_DECAY;
      L_DECAY:    if (cnt_r == 2'd3) state_nxt = L_SUM;
      L_SUM:      state_nxt = L_RAD_GO;
      L_RAD_GO: begin
        div_start = 1'b1;
        state_nxt = L_DIV_RAD;
      end
      L_DIV_RAD:  if (div_done) state_nxt = L_FINISH;
      L_FINISH: begin
        done      = 1'b1;
        state_nxt = L_IDLE;
      end
      default:    state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= L_IDLE;
      center_r <= '0;
      spread_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        L_IDLE: begin
          if (cmd.start) begin
            if (cmd.first) begin
              center_r <= sat_s32(sf);
            end
            sf_r  <= sf;
            mag_r <= mag;
            neg_r <= delta[63];
          end
        end
        L_CENTER: center_r <= sat_s32(newc);
        L_DIFF: begin
          a_r   <= same_sign ? mag_r : 64'd0;
          b_r   <= same_sign ? an : 64'd0;
          acc_r <= '0;
          cnt_r <= '0;
        end
        L_TERM, L_DECAY: begin
          acc_r <= acc_r + part;
          cnt_r <= cnt_r + 2'd1;
        end
        L_TSAT: begin
          term_r <= (|acc_r[127:63+FRAC_BITS]) ? {63{1'b1}} : acc_r[62+FRAC_BITS:FRAC_BITS];
          a_r    <= {1'b0, spread_r};
          b_r    <= {47'd0, decay};
          acc_r  <= '0;
          cnt_r  <= '0;
        end
        L_SUM:     spread_r <= dv[63] ? {63{1'b1}} : dv[62:0];
        L_DIV_RAD: if (div_done) rad_quo_r <= div_quo;
        default: ;
      endcase
    end
  end

  assign center  = center_r;
  assign spread  = spread_r;
  assign rad_quo = rad_quo_r;

endmodule

@@ src/decayed_cluster_stats_update.sv @@
// Each input transaction passes through both lanes and then the root before out_tvalid rises.
// Each lane runs two divisions (centre step, then radius term); the first sample needs only one.
// A new sample is taken only once the previous one has passed through the lanes and root
// and its result has been loaded into the output register.
// Reset: synchronous active-low rst_n empties the cluster and sets the decay to 1.0.
// A finished result waits in the output register while the next sample is accepted.
`timescale 1ns / 1ps
module decayed_cluster_stats_update #(
  parameter int SAMPLE_BITS = dcs_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = dcs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample_x, sample_y
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // mid_x, mid_y, cluster_weight, spread_x, spread_y, cluster_radius, points_seen
  output logic [287:0]                      out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [16:0]                       cfg_wr_data
);
  import dcs_pkg::*;

  localparam logic [31:0] W_ONE = 32'd1 << FRAC_BITS;

  top_state_t state_r, state_nxt;

  logic [16:0]            dec_r, dec_eff_r, dec_eff;
  logic [31:0]            weight_r, count_r;
  logic [SAMPLE_BITS-1:0] sx_r, sy_r;
  logic                   first_r, radsat_r, out_valid_r;
  logic [31:0]            rad_r;
  logic [287:0]           out_r;

  logic [48:0]  wprod;
  logic [32:0]  wsum;
  lane_cmd_t    cmd;
  logic         done_x, done_y, sqrt_start, sqrt_done, load_out;
  logic signed [31:0] cx, cy;
  logic [62:0]  spx, spy, qx, qy;
  logic [63:0]  rsum;
  logic [31:0]  root;

  assign dec_eff = (dec_r > DECAY_ONE) ? DECAY_ONE : dec_r;
  assign wprod   = weight_r * dec_eff;
  assign wsum    = 33'(wprod >> DECAY_FRAC) + {1'b0, W_ONE};
  assign rsum    = {1'b0, qx} + {1'b0, qy};

  dcs_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sample(sx_r), .weight(weight_r),
    .decay(dec_eff_r), .done(done_x), .center(cx), .spread(spx), .rad_quo(qx)
  );

  dcs_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sample(sy_r), .weight(weight_r),
    .decay(dec_eff_r), .done(done_y), .center(cy), .spread(spy), .rad_quo(qy)
  );

  dcs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (64'(rsum << FRAC_BITS)),
    .done     (sqrt_done),
    .root     (root)
  );

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd.start  = 1'b0;
    cmd.first  = first_r;
    sqrt_start = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      T_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = T_WGT;
      end
      T_WGT:   state_nxt = T_START;
      T_START: begin
        cmd.start = 1'b1;
        state_nxt = T_LANE;
      end
      T_LANE:  if (done_x) state_nxt = T_SQRT;
      T_SQRT: begin
        sqrt_start = 1'b1;
        state_nxt  = T_SQW;
      end
      T_SQW:   if (sqrt_done) state_nxt = T_OUT;
      T_OUT: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      dec_r       <= DECAY_ONE;
      weight_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) dec_r <= cfg_wr_data;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (in_tvalid) begin
            sx_r <= in_tdata[SAMPLE_BITS-1:0];
            sy_r <= in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
          end
        end
        T_WGT: begin
          dec_eff_r <= dec_eff;
          first_r   <= (weight_r == 32'd0);
          if (weight_r == 32'd0) begin
            weight_r <= W_ONE;
          end else begin
            weight_r <= wsum[32] ? 32'hFFFFFFFF : wsum[31:0];
          end
          if (count_r != 32'hFFFFFFFF) count_r <= count_r + 32'd1;
        end
        T_SQRT:  radsat_r <= |rsum[63:64-FRAC_BITS];
        T_SQW:   if (sqrt_done) rad_r <= radsat_r ? 32'hFFFFFFFF : root;
        default: ;
      endcase
      if (load_out) begin
        out_r <= {2'b00, count_r, rad_r, spy, spx, weight_r, cy, cx};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // Both lanes run the same fixed schedule, so they must finish together.
  assert property (@(posedge clk) disable iff (!rst_n) done_x == done_y)
    else $error("lanes finished out of step");
  assert property (@(posedge clk) disable iff (!rst_n) done_x |-> state_r == T_LANE)
    else $error("lane finished while not awaited");
  assert property (@(posedge clk) disable iff (!rst_n) load_out |-> weight_r >= W_ONE)
    else $error("result loaded with a weight below one");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == T_WGT)
    else $error("accepted sample not taken up");

endmodule

@@ tb/dcs_checker.sv @@
// Checker for the decayed cluster statistics block: watches the channels, predicts and compares.
`timescale 1ns / 1ps
module dcs_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [31:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [287:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [16:0]  cfg_wr_data,
  output int           pending,
  output int           fail_count
);

  localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX32 = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] mid_x;
    logic [31:0] mid_y;
    logic [31:0] weight;
    logic [62:0] spread_x;
    logic [62:0] spread_y;
    logic [31:0] radius;
    logic [31:0] points;
  } cluster_stats_t;

  cluster_stats_t stats_due[$];

  // Cluster state tracked alongside the block.
  logic signed [31:0] mean_x, mean_y;
  logic [31:0]        weight;
  logic [63:0]        spread_x, spread_y;
  logic [31:0]        count;
  logic [16:0]        decay;

  function automatic logic [63:0] scale_down(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    p = p >> 16;
    if (p > {64'd0, MAX63}) return MAX63;
    return p[63:0];
  endfunction

  function automatic logic [63:0] frac_quotient(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, r;
    if (d == 0) return MAX63;
    q = n / d;
    r = n % d;
    if (q >= (64'd1 << 47)) return MAX63;
    return (q << 16) + ((r << 16) / d);
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp_s32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Moves one centre coordinate towards the sample and returns the new spread.
  function automatic logic [63:0] move_axis(inout logic signed [31:0] c,
                                            input logic [63:0] spread,
                                            input logic signed [15:0] s,
                                            input logic [31:0] w, input logic [16:0] dec);
    longint sf, oldc, newc, delta, dnew;
    logic [63:0] mag, step, term, ao, an, dv;
    sf = longint'(s) * 65536;
    oldc = c;
    delta = sf - oldc;
    mag = delta < 0 ? -delta : delta;
    step = frac_quotient(mag, {32'd0, w});
    if (step > mag) step = mag;
    newc = delta < 0 ? oldc - longint'(step) : oldc + longint'(step);
    c = clamp_s32(newc);
    newc = c;
    dnew = sf - newc;
    term = 0;
    if ((delta >= 0 && dnew >= 0) || (delta <= 0 && dnew <= 0)) begin
      ao = delta < 0 ? -delta : delta;
      an = dnew < 0 ? -dnew : dnew;
      term = scale_down(ao, an);
    end
    dv = scale_down(spread, {47'd0, dec}) + term;
    if (dv > MAX63) dv = MAX63;
    return dv;
  endfunction

  function automatic cluster_stats_t absorb_sample(input logic signed [15:0] sx,
                                                   input logic signed [15:0] sy);
    cluster_stats_t r;
    logic [16:0] dec;
    logic [63:0] w, sum, rad;
    dec = decay > dcs_pkg::DECAY_ONE ? dcs_pkg::DECAY_ONE : decay;
    if (weight == 0) begin
      mean_x = clamp_s32(longint'(sx) * 65536);
      mean_y = clamp_s32(longint'(sy) * 65536);
      weight = 32'h0001_0000;
    end else begin
      w = ((64'(weight) * dec) >> 16) + 64'h1_0000;
      if (w > MAX32) w = MAX32;
      weight = w[31:0];
      spread_x = move_axis(mean_x, spread_x, sx, weight, dec);
      spread_y = move_axis(mean_y, spread_y, sy, weight, dec);
    end
    if (count != 32'hFFFF_FFFF) count = count + 1;
    sum = frac_quotient(spread_x, {32'd0, weight}) + frac_quotient(spread_y, {32'd0, weight});
    if (sum >= (64'd1 << 48)) begin
      rad = MAX32;
    end else begin
      rad = int_root(sum << 16);
      if (rad > MAX32) rad = MAX32;
    end
    r.mid_x = mean_x;
    r.mid_y = mean_y;
    r.weight = weight;
    r.spread_x = spread_x[62:0];
    r.spread_y = spread_y[62:0];
    r.radius = rad[31:0];
    r.points = count;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = stats_due.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    cluster_stats_t e;
    if (!rst_n) begin
      mean_x = 0;
      mean_y = 0;
      weight = 0;
      spread_x = 0;
      spread_y = 0;
      count = 0;
      decay = dcs_pkg::DECAY_ONE;
      stats_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (stats_due.size() == 0) begin
          $error("result transaction with no sample outstanding");
          fail_count++;
        end else begin
          e = stats_due.pop_front();
          check_field("mid_x", e.mid_x, out_tdata[31:0]);
          check_field("mid_y", e.mid_y, out_tdata[63:32]);
          check_field("cluster_weight", e.weight, out_tdata[95:64]);
          check_field("spread_x", e.spread_x, out_tdata[158:96]);
          check_field("spread_y", e.spread_y, out_tdata[221:159]);
          check_field("cluster_radius", e.radius, out_tdata[253:222]);
          check_field("points_seen", e.points, out_tdata[285:254]);
        end
      end
      if (in_tvalid && in_tready)
        stats_due.push_back(absorb_sample(in_tdata[15:0], in_tdata[31:16]));
      if (cfg_wr_en) decay = cfg_wr_data;
    end
  end

endmodule

@@ tb/testbench.sv @@
// Top of the testbench: clock, reset, sample and register stimulus, and the verdict.
`timescale 1ns / 1ps
module testbench;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [287:0] out_tdata;
  logic         cfg_wr_en;
  logic [16:0]  cfg_wr_data;
  int           pending;
  int           fail_count;

  bit quiet;
  bit hold_req;
  logic signed [15:0] last_x, last_y;

  decayed_cluster_stats_update u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  dcs_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("Verification failed");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, none once quiet.
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready = 0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        out_tready = 1;
      end
    end
  end

  task automatic push_sample(input logic signed [15:0] x, input logic signed [15:0] y);
    in_tvalid = 1;
    in_tdata = {y, x};
    last_x = x;
    last_y = y;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid = 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic write_decay(input logic [16:0] value);
    in_tvalid = 0;
    while (pending != 0) @(negedge clk);
    repeat (130) @(negedge clk);
    cfg_wr_en = 1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  function automatic logic signed [15:0] pick_coord(input logic signed [15:0] near);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return near + $signed(16'($urandom_range(0, 64))) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) push_sample(pick_coord(last_x), pick_coord(last_y));
  endtask

  initial begin
    logic [16:0] decays[5];
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    quiet = 0;
    hold_req = 0;
    last_x = 0;
    last_y = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;

    // Directed: first sample, extremes and swings between corners with no decay.
    write_decay(dcs_pkg::DECAY_ONE);
    push_sample(16'sh7FFF, 16'sh8000);
    push_sample(16'sh8000, 16'sh7FFF);
    push_sample(16'sh7FFF, 16'sh7FFF);
    push_sample(16'sh8000, 16'sh8000);
    push_sample(0, 0);
    push_sample(-1, 1);
    push_sample(16'sh5555, 16'shAAAA);
    push_sample(16'shAAAA, 16'sh5555);
    // Full decay, then a factor above one, which counts as no decay.
    write_decay(17'd0);
    push_sample(16'sh7FFF, 16'sh8000);
    push_sample(100, -100);
    push_sample(16'sh8000, 16'sh7FFF);
    write_decay(17'h1FFFF);
    push_sample(16'sh7FFF, 16'sh7FFF);
    push_sample(16'sh8000, 16'sh8000);
    push_sample(1, -1);
    write_decay(17'd65535);
    push_sample(16'sh7FFF, 16'sh8000);
    push_sample(16'sh8000, 16'sh7FFF);

    // Long hold-off on the result side so the block backs up into its input.
    hold_req = 1;
    random_run(12);

    decays = '{dcs_pkg::DECAY_ONE, 17'd32768, 17'd0, 17'd65535, 17'h1FFFF};
    foreach (decays[i]) begin
      write_decay(decays[i]);
      random_run(130);
      write_decay(17'($urandom_range(0, 65536)));
      random_run(70);
    end
    quiet = 1;
    random_run(20);

    in_tvalid = 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ decayed_cluster_stats_update.f @@
src/dcs_pkg.sv
src/dcs_div.sv
src/dcs_sqrt.sv
src/dcs_lane.sv
src/decayed_cluster_stats_update.sv
tb/dcs_checker.sv
tb/testbench.sv
